>>> rtl/bdlp_pkg.sv
// Package for the button debouncer with long-press detection.
// Holds the register map, lane limits and the structs passed between the lanes and the top level.
// No dependencies.
package bdlp_pkg;

   // Data paths of the item and the result are eight lanes wide.
   localparam int unsigned LANE_WIDTH  = 8;
   localparam int unsigned COUNT_WIDTH = 4;
   localparam int unsigned TIME_WIDTH  = 32;
   localparam int unsigned MS_WIDTH    = 16;
   localparam int unsigned ADDR_WIDTH  = 4;
   localparam int unsigned DATA_WIDTH  = 32;

   // Opcodes of a request transaction.
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_BASELINE = 1'b1;

   // Register index, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_BUTTON_COUNT  = 2'd0,
      REG_DEBOUNCE_MS   = 2'd1,
      REG_LONG_PRESS_MS = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [MS_WIDTH-1:0] debounce_ms;
      logic [MS_WIDTH-1:0] long_press_ms;
   } lane_cfg_type;

   typedef struct packed {
      logic press;
      logic release_edge;
      logic long_press;
      logic down;
   } lane_result_type;

endpackage

>>> rtl/button_debounce_long_press.sv
// Top level of the button debouncer with long-press detection.
// Input register, per-lane debounce logic, result register and the APB register file.
// Depends on bdlp_pkg and bdlp_lane.
//
//  channel  | ports                       | moves
//  ---------+-----------------------------+------------------------------------------
//  req      | req_valid / req_ready       | one tick or baseline transaction
//  rsp      | rsp_valid / rsp_ready       | edges and debounced levels, one per req
//  csr      | APB psel/penable/pwrite ... | button_count, debounce_ms, long_press_ms
//
// One transaction per cycle sustained while rsp_ready holds; an accepted transaction first
// sits in the input register, then passes through the lane logic into the result register,
// which raises rsp_valid. Every lane does its subtract and compare in parallel in the lane logic.
// Reset clears all lane state (levels, flags and time stamps) and the registers to their
// defaults at once; no clearing pass. A stalled rsp holds the result register, and req_ready
// falls only when both the input and the result register are full.
module button_debounce_long_press #(
   parameter int unsigned MAX_BUTTONS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [31:0]                          req_now_ms,
   input  logic [7:0]                           req_raw_buttons,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_press_edges,
   output logic [7:0]                           rsp_release_edges,
   output logic [7:0]                           rsp_long_press_edges,
   output logic [7:0]                           rsp_down_state,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bdlp_pkg::ADDR_WIDTH-1:0]      csr_paddr,
   input  logic [bdlp_pkg::DATA_WIDTH-1:0]      csr_pwdata,
   output logic [bdlp_pkg::DATA_WIDTH-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   // lanes actually built: never more than the eight bits of the fields
   localparam int unsigned LANES = (MAX_BUTTONS < bdlp_pkg::LANE_WIDTH) ?
                                   MAX_BUTTONS : bdlp_pkg::LANE_WIDTH;
   localparam logic [bdlp_pkg::COUNT_WIDTH-1:0] LANES_COUNT = LANES[bdlp_pkg::COUNT_WIDTH-1:0];

   // ---------------- registers ----------------
   logic [bdlp_pkg::COUNT_WIDTH-1:0] button_count_ff;
   logic [bdlp_pkg::MS_WIDTH-1:0]    debounce_ms_ff;
   logic [bdlp_pkg::MS_WIDTH-1:0]    long_press_ms_ff;
   logic                             csr_write;
   bdlp_pkg::reg_index_type          csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = bdlp_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         button_count_ff  <= 4'd8;
         debounce_ms_ff   <= 16'd30;
         long_press_ms_ff <= 16'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            bdlp_pkg::REG_BUTTON_COUNT:  button_count_ff  <= csr_pwdata[3:0];
            bdlp_pkg::REG_DEBOUNCE_MS:   debounce_ms_ff   <= csr_pwdata[15:0];
            bdlp_pkg::REG_LONG_PRESS_MS: long_press_ms_ff <= csr_pwdata[15:0];
            default: ;  // drop writes outside the map
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bdlp_pkg::REG_BUTTON_COUNT:  csr_prdata = {28'd0, button_count_ff};
         bdlp_pkg::REG_DEBOUNCE_MS:   csr_prdata = {16'd0, debounce_ms_ff};
         bdlp_pkg::REG_LONG_PRESS_MS: csr_prdata = {16'd0, long_press_ms_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   logic        in_valid_ff;
   logic        in_opcode_ff;
   logic [31:0] in_now_ff;
   logic [7:0]  in_raw_ff;
   logic        rsp_valid_ff;
   logic        advance;

   // advance the input register into the result register when that one is free or drains
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload: capture on acceptance, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_now_ff    <= req_now_ms;
         in_raw_ff    <= req_raw_buttons;
      end
   end

   // ---------------- lanes ----------------
   logic [bdlp_pkg::COUNT_WIDTH-1:0] active_count;
   logic [7:0]                       active_mask;
   logic [7:0]                       press_in, release_in, long_in, down_in;
   bdlp_pkg::lane_cfg_type           lane_cfg;

   // saturate the configured count to the lanes built
   assign active_count           = (button_count_ff > LANES_COUNT) ? LANES_COUNT : button_count_ff;
   assign lane_cfg.debounce_ms   = debounce_ms_ff;
   assign lane_cfg.long_press_ms = long_press_ms_ff;

   for (genvar k = 0; k < bdlp_pkg::LANE_WIDTH; k++) begin : g_lane
      if (k < LANES) begin : g_used
         bdlp_pkg::lane_result_type lane_result;

         assign active_mask[k] = (k < int'(active_count));

         bdlp_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .enable  (advance && active_mask[k]),
            .opcode  (in_opcode_ff),
            .now_ms  (in_now_ff),
            .raw     (in_raw_ff[k]),
            .cfg     (lane_cfg),
            .result  (lane_result)
         );

         // lanes not in use report nothing
         assign press_in[k]   = lane_result.press        && active_mask[k];
         assign release_in[k] = lane_result.release_edge && active_mask[k];
         assign long_in[k]    = lane_result.long_press   && active_mask[k];
         assign down_in[k]    = lane_result.down         && active_mask[k];
      end else begin : g_unused
         assign active_mask[k] = 1'b0;
         assign press_in[k]    = 1'b0;
         assign release_in[k]  = 1'b0;
         assign long_in[k]     = 1'b0;
         assign down_in[k]     = 1'b0;
      end
   end

   // ---------------- result register ----------------
   logic [7:0] press_ff, release_ff, long_ff, down_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         press_ff   <= press_in;
         release_ff <= release_in;
         long_ff    <= long_in;
         down_ff    <= down_in;
      end
   end

   assign rsp_press_edges      = press_ff;
   assign rsp_release_edges    = release_ff;
   assign rsp_long_press_edges = long_ff;
   assign rsp_down_state       = down_ff;

`ifndef SYNTHESIS
   // a lane never commits a press and a release in the same transaction
   a_press_release_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((press_ff & release_ff) == 8'd0))
      else $error("press and release edge on the same lane");

   // a committed press leaves the lane down
   a_press_is_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((press_ff & ~down_ff) == 8'd0))
      else $error("press edge on a lane that is not down");

   // a committed release leaves the lane up
   a_release_is_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((release_ff & down_ff) == 8'd0))
      else $error("release edge on a lane that is still down");

   // long press only fires on a held lane
   a_long_is_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((long_ff & ~down_ff) == 8'd0))
      else $error("long-press edge on a lane that is not down");

   // a stalled result with a full input register must block new transactions
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while both stages are full");
`endif

endmodule

>>> rtl/bdlp_lane.sv
// One button lane: raw level tracking, debounce commit and long-press detection.
// Holds the lane's state in flip-flops and updates it when enabled.
// Depends on bdlp_pkg.
module bdlp_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   opcode,
   input  logic [bdlp_pkg::TIME_WIDTH-1:0]        now_ms,
   input  logic                                   raw,
   input  bdlp_pkg::lane_cfg_type                 cfg,
   output bdlp_pkg::lane_result_type              result
);

   logic                              last_raw_ff, last_raw_in;
   logic                              debounced_ff, debounced_in;
   logic                              fired_ff, fired_in;
   logic [bdlp_pkg::TIME_WIDTH-1:0]   change_time_ff, change_time_in;
   logic [bdlp_pkg::TIME_WIDTH-1:0]   press_time_ff, press_time_in;
   logic [bdlp_pkg::TIME_WIDTH-1:0]   since_change;
   logic [bdlp_pkg::TIME_WIDTH-1:0]   since_press;

   assign since_change = now_ms - change_time_ff;

   always_comb begin
      last_raw_in    = last_raw_ff;
      debounced_in   = debounced_ff;
      fired_in       = fired_ff;
      change_time_in = change_time_ff;
      press_time_in  = press_time_ff;
      since_press    = '0;
      result         = '0;
      if (opcode == bdlp_pkg::OP_BASELINE) begin
         // adopt the raw level as baseline, no edges
         last_raw_in  = raw;
         debounced_in = raw;
      end else begin
         if (raw != last_raw_ff) begin
            // restart the window
            last_raw_in    = raw;
            change_time_in = now_ms;
         end else if (raw != debounced_ff &&
                      since_change >= {{(bdlp_pkg::TIME_WIDTH-bdlp_pkg::MS_WIDTH){1'b0}},
                                       cfg.debounce_ms}) begin
            debounced_in = raw;
            if (raw) begin
               press_time_in = now_ms;
               fired_in      = 1'b0;
               result.press  = 1'b1;
            end else begin
               result.release_edge = 1'b1;
            end
         end
         since_press = now_ms - press_time_in;
         if (debounced_in && !fired_in &&
             since_press >= {{(bdlp_pkg::TIME_WIDTH-bdlp_pkg::MS_WIDTH){1'b0}},
                             cfg.long_press_ms}) begin
            fired_in          = 1'b1;
            result.long_press = 1'b1;
         end
      end
      result.down = debounced_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         debounced_ff   <= 1'b0;
         fired_ff       <= 1'b0;
         change_time_ff <= '0;
         press_time_ff  <= '0;
      end else if (enable) begin
         last_raw_ff    <= last_raw_in;
         debounced_ff   <= debounced_in;
         fired_ff       <= fired_in;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
      end
   end

endmodule
